/* sv/nti_pkg.sv */
`default_nettype none
package nti_pkg;

  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 64;
  localparam int INDEX_W = 4;
  localparam int PAY_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_BY_ADDR  = 2'd1,
    FUNC_BY_INDEX = 2'd2
  } func_t;

endpackage
`default_nettype wire

/* sv/nti_req_if.sv */
`default_nettype none
interface nti_req_if;
  import nti_pkg::*;

  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [ADDR_W-1:0]    address;
  logic [INDEX_W-1:0]   index;
  logic [PAY_W-1:0]     payload;

  modport source (output valid, output func, output address, output index,
                  output payload, input ready);
  modport sink   (input valid, input func, input address, input index,
                  input payload, output ready);
endinterface
`default_nettype wire

/* sv/nti_rsp_if.sv */
`default_nettype none
interface nti_rsp_if;
  import nti_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [INDEX_W-1:0]   slot;
  logic [ADDR_W-1:0]    entry_address;
  logic [PAY_W-1:0]     entry_payload;

  modport source (output valid, output found, output slot, output entry_address,
                  output entry_payload, input ready);
  modport sink   (input valid, input found, input slot, input entry_address,
                  input entry_payload, output ready);
endinterface
`default_nettype wire

/* sv/node_table_insert_lookup.sv */
`default_nettype none
// Node table: TABLE_DEPTH entries, each a 64-bit address key plus a payload of
// PAYLOAD_WIDTH bits, kept in one RAM and searched by a single key comparator
// that looks at one entry per cycle. An all-zero key is never stored; per-slot
// occupancy flops mark free slots and are cleared at reset, so the table is
// empty right away with no clearing pass. func 0 adds or updates (matching key
// first, else lowest free slot, else not found), func 1 looks up by address,
// func 2 reads the slot given by index if it is occupied. One request is in
// flight at a time; each gives one result beat. Add and address lookup read
// the entries in order, comparing each in the cycle after its RAM read; a hit
// ends the scan early. Lookup by index does a single RAM read; a zero address
// or unused func code goes straight to the result. The result sits in an output
// register, so the next request can be accepted while it waits to be taken.
module node_table_insert_lookup #(
  parameter int TABLE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nti_req_if.sink   in_req,
  nti_rsp_if.source out_rsp
);
  import nti_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;
  localparam int PX_W  = (PAYLOAD_WIDTH > PAY_W) ? PAYLOAD_WIDTH : PAY_W;
  localparam int ENT_W = ADDR_W + PAYLOAD_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_IDX  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  func_t                      func_r, func_nxt;
  logic [ADDR_W-1:0]          addr_r, addr_nxt;
  logic [PAYLOAD_WIDTH-1:0]   pay_r, pay_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]           chk_idx_r, chk_idx_nxt;
  logic                       empty_fnd_r, empty_fnd_nxt;
  logic [IDX_W-1:0]           empty_idx_r, empty_idx_nxt;
  logic [TABLE_DEPTH-1:0]     valid_r, valid_nxt;

  logic                       res_found_r, res_found_nxt;
  logic [IDX_W-1:0]           res_slot_r, res_slot_nxt;
  logic [ADDR_W-1:0]          res_addr_r, res_addr_nxt;
  logic [PAYLOAD_WIDTH-1:0]   res_pay_r, res_pay_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [INDEX_W-1:0]         out_slot_r, out_slot_nxt;
  logic [ADDR_W-1:0]          out_addr_r, out_addr_nxt;
  logic [PAY_W-1:0]           out_pay_r, out_pay_nxt;

  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [IDX_W-1:0]           ram_raddr;
  logic [ENT_W-1:0]           ram_rdata;
  logic [ADDR_W-1:0]          rd_key;
  logic [PAYLOAD_WIDTH-1:0]   rd_pay;

  logic [EXT_W-1:0]           idx_ext;
  logic [EXT_W-1:0]           slot_ext;
  logic [PX_W-1:0]            pay_in_ext;
  logic [PX_W-1:0]            res_pay_ext;
  logic                       slot_ok;
  logic                       hit;

  assign rd_key      = ram_rdata[ENT_W-1 -: ADDR_W];
  assign rd_pay      = ram_rdata[PAYLOAD_WIDTH-1:0];
  assign idx_ext     = EXT_W'(in_req.index);
  assign slot_ext    = EXT_W'(res_slot_r);
  assign pay_in_ext  = PX_W'(in_req.payload);
  assign res_pay_ext = PX_W'(res_pay_r);
  assign slot_ok     = valid_r[chk_idx_r];
  assign hit         = chk_vld_r && slot_ok && (rd_key == addr_r);

  nti_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({addr_r, pay_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    pay_nxt       = pay_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    empty_fnd_nxt = empty_fnd_r;
    empty_idx_nxt = empty_idx_r;
    valid_nxt     = valid_r;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    res_addr_nxt  = res_addr_r;
    res_pay_nxt   = res_pay_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    out_addr_nxt  = out_addr_r;
    out_pay_nxt   = out_pay_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r;
    ram_raddr     = cnt_r[IDX_W-1:0];

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          func_nxt      = in_req.func;
          addr_nxt      = in_req.address;
          pay_nxt       = pay_in_ext[PAYLOAD_WIDTH-1:0];
          idx_nxt       = idx_ext[IDX_W-1:0];
          cnt_nxt       = '0;
          chk_vld_nxt   = 1'b0;
          empty_fnd_nxt = 1'b0;
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_addr_nxt  = '0;
          res_pay_nxt   = '0;
          case (in_req.func)
            FUNC_ADD, FUNC_BY_ADDR: begin
              // zero key never names an entry
              state_nxt = (in_req.address != '0) ? S_SCAN : S_DONE;
            end
            FUNC_BY_INDEX: begin
              if (idx_ext < EXT_W'(TABLE_DEPTH)) begin
                ram_raddr = idx_ext[IDX_W-1:0];
                state_nxt = S_IDX;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read issue runs one entry ahead of the compare
        if (cnt_r < CNT_W'(TABLE_DEPTH)) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end

        if (hit) begin
          res_found_nxt = 1'b1;
          res_slot_nxt  = chk_idx_r;
          chk_vld_nxt   = 1'b0;
          state_nxt     = S_DONE;
          if (func_r == FUNC_ADD) begin
            ram_we       = 1'b1;
            ram_waddr    = chk_idx_r;
            res_addr_nxt = addr_r;
            res_pay_nxt  = pay_r;
          end else begin
            res_addr_nxt = rd_key;
            res_pay_nxt  = rd_pay;
          end
        end else if (chk_vld_r) begin
          if (!slot_ok && !empty_fnd_r) begin
            empty_fnd_nxt = 1'b1;
            empty_idx_nxt = chk_idx_r;
          end
          if (chk_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = S_DONE;
            // no match: fill lowest free slot, if any
            if ((func_r == FUNC_ADD) && (empty_fnd_r || !slot_ok)) begin
              ram_we                = 1'b1;
              ram_waddr             = empty_fnd_r ? empty_idx_r : chk_idx_r;
              valid_nxt[ram_waddr]  = 1'b1;
              res_found_nxt         = 1'b1;
              res_slot_nxt          = ram_waddr;
              res_addr_nxt          = addr_r;
              res_pay_nxt           = pay_r;
            end
          end
        end
      end

      S_IDX: begin
        if (valid_r[idx_r]) begin
          res_found_nxt = 1'b1;
          res_slot_nxt  = idx_r;
          res_addr_nxt  = rd_key;
          res_pay_nxt   = rd_pay;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_slot_nxt  = slot_ext[INDEX_W-1:0];
          out_addr_nxt  = res_addr_r;
          out_pay_nxt   = res_pay_ext[PAY_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      empty_fnd_r <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      empty_fnd_r <= empty_fnd_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    pay_r       <= pay_nxt;
    idx_r       <= idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    res_addr_r  <= res_addr_nxt;
    res_pay_r   <= res_pay_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
    out_addr_r  <= out_addr_nxt;
    out_pay_r   <= out_pay_nxt;
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.found         = out_found_r;
  assign out_rsp.slot          = out_slot_r;
  assign out_rsp.entry_address = out_addr_r;
  assign out_rsp.entry_payload = out_pay_r;

endmodule
`default_nettype wire

/* sv/nti_ram.sv */
`default_nettype none
module nti_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sim/node_table_tb_pkg.sv */
package node_table_tb_pkg;
  import nti_pkg::*;

  localparam int          SLOTS     = 16;
  localparam logic [1:0]  FUNC_RSVD = 2'd3;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] slot;
    logic [ADDR_W-1:0]  entry_address;
    logic [PAY_W-1:0]   entry_payload;
  } node_entry_t;

  class node_table_mirror;
    logic [ADDR_W-1:0] keys [SLOTS];
    logic [PAY_W-1:0]  payloads [SLOTS];
    node_entry_t       owed_entries [$];
    int                errors;

    function new();
      foreach (keys[i]) begin
        keys[i]     = '0;
        payloads[i] = '0;
      end
      errors = 0;
    endfunction

    // lowest slot holding this key, -1 if none (key 0 finds a free slot)
    function int slot_of(logic [ADDR_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_request(func_t f, logic [ADDR_W-1:0] a, logic [INDEX_W-1:0] idx,
                               logic [PAY_W-1:0] p);
      node_entry_t r;
      int          pos;
      r   = '0;
      pos = -1;
      case (f)
        FUNC_ADD: begin
          if (a != '0) begin
            pos = slot_of(a);
            if (pos < 0) pos = slot_of('0);
            if (pos >= 0) begin
              keys[pos]     = a;
              payloads[pos] = p;
            end
          end
        end
        FUNC_BY_ADDR: begin
          if (a != '0) pos = slot_of(a);
        end
        FUNC_BY_INDEX: begin
          if (keys[idx] != '0) pos = idx;
        end
        default: ;
      endcase
      if (pos >= 0) begin
        r.found         = 1'b1;
        r.slot          = pos[INDEX_W-1:0];
        r.entry_address = keys[pos];
        r.entry_payload = payloads[pos];
      end
      owed_entries.push_back(r);
    endfunction

    function void compare_field(string name, logic [ADDR_W-1:0] exp_v,
                                logic [ADDR_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(node_entry_t act);
      node_entry_t e;
      if (owed_entries.size() == 0) begin
        $error("result beat with nothing outstanding: %p", act);
        errors++;
        return;
      end
      e = owed_entries.pop_front();
      compare_field("found", 64'(e.found), 64'(act.found));
      compare_field("slot", 64'(e.slot), 64'(act.slot));
      compare_field("entry_address", e.entry_address, act.entry_address);
      compare_field("entry_payload", 64'(e.entry_payload), 64'(act.entry_payload));
    endfunction

    function int outstanding();
      return owed_entries.size();
    endfunction
  endclass

endpackage

/* sim/tb_node_table_insert_lookup.sv */
module tb_node_table_insert_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import nti_pkg::*;
  import node_table_tb_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 300000;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   sent_count;
  int   taken_count;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  node_table_mirror  mirror;

  nti_req_if req_if ();
  nti_rsp_if rsp_if ();

  node_table_insert_lookup dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_node_table_insert_lookup: done, errors");
      $finish;
    end
  end

  // idle-free stretches land at different times on each side
  function automatic int draw_gap(int n, int quiet_phase);
    if ((n / 40) % 3 == quiet_phase) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic send_request(input logic [1:0] f, input logic [ADDR_W-1:0] a,
                              input logic [INDEX_W-1:0] idx, input logic [PAY_W-1:0] p);
    int gap;
    gap = draw_gap(sent_count, 2);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= func_t'(f);
    req_if.address <= a;
    req_if.index   <= idx;
    req_if.payload <= p;
    do @(posedge clk); while (!req_if.ready);
    mirror.note_request(func_t'(f), a, idx, p);
    sent_count++;
  endtask

  task automatic take_results();
    int          gap;
    node_entry_t beat;
    forever begin
      gap = draw_gap(taken_count, 1);
      @(negedge clk);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      beat.found         = rsp_if.found;
      beat.slot          = rsp_if.slot;
      beat.entry_address = rsp_if.entry_address;
      beat.entry_payload = rsp_if.entry_payload;
      mirror.check_response(beat);
      taken_count++;
    end
  endtask

  task automatic run_directed();
    logic [ADDR_W-1:0] ones;
    ones = '1;
    send_request(FUNC_BY_INDEX, '0, 4'd0, '0);      // empty table
    send_request(FUNC_BY_INDEX, '0, 4'd15, '0);
    send_request(FUNC_ADD, '0, 4'd0, 32'hDEAD_BEEF);  // zero key is refused
    send_request(FUNC_BY_ADDR, '0, 4'd0, '0);
    send_request(FUNC_RSVD, ones, 4'd15, '1);
    send_request(FUNC_ADD, ones, 4'd15, '1);
    send_request(FUNC_ADD, 64'd1, 4'd0, '0);
    send_request(FUNC_ADD, 64'h8000_0000_0000_0000, 4'd0, 32'h8000_0001);
    send_request(FUNC_BY_ADDR, ones, 4'd0, '0);
    send_request(FUNC_ADD, ones, 4'd0, 32'h5A5A_A5A5);  // update in place
    send_request(FUNC_BY_ADDR, ones, 4'd0, '0);
    send_request(FUNC_BY_ADDR, 64'h1234_5678_9ABC_DEF0, 4'd0, '0);
    send_request(FUNC_BY_INDEX, '0, 4'd0, '0);
    send_request(FUNC_BY_INDEX, '0, 4'd1, '0);
    send_request(FUNC_BY_INDEX, '0, 4'd2, '0);
    send_request(FUNC_BY_INDEX, '0, 4'd3, '0);
    send_request(FUNC_BY_ADDR, 64'd1, 4'd0, '0);
    send_request(FUNC_RSVD, '0, 4'd0, '0);
  endtask

  task automatic run_random();
    int                r;
    int                s;
    logic [1:0]        f;
    logic [ADDR_W-1:0] a;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      f = FUNC_ADD;
      else if (r < 75) f = FUNC_BY_ADDR;
      else if (r < 95) f = FUNC_BY_INDEX;
      else             f = FUNC_RSVD;
      // mostly a small key pool, so updates and hits dominate and the table fills
      s = $urandom_range(0, 19);
      if (s == 0)     a = '0;
      else if (s < 4) a = {$urandom, $urandom};
      else            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(f, a, INDEX_W'($urandom_range(0, 15)), $urandom);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cycle_count    = 0;
    sent_count     = 0;
    taken_count    = 0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_ADD;
    req_if.address = '0;
    req_if.index   = '0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    mirror         = new();

    addr_pool[0] = '1;
    addr_pool[1] = 64'd1;
    addr_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < POOL_SIZE; i++) begin
      addr_pool[i] = {$urandom, $urandom};
      if (addr_pool[i] == '0) addr_pool[i] = 64'h5;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      take_results();
    join_none

    run_directed();
    run_random();
    @(negedge clk);
    req_if.valid <= 1'b0;

    while (mirror.outstanding() != 0) @(posedge clk);
    // watch for stray beats after the last expected one
    repeat (50) @(posedge clk);

    if (mirror.errors == 0) begin
      $display("tb_node_table_insert_lookup: done, clean");
    end else begin
      $display("tb_node_table_insert_lookup: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/nti_pkg.sv
sv/nti_req_if.sv
sv/nti_rsp_if.sv
sv/nti_ram.sv
sv/node_table_insert_lookup.sv
sim/node_table_tb_pkg.sv
sim/tb_node_table_insert_lookup.sv
